/* hdl/multi_tap_feedback_delay_mixer_top_assert.svh */
// assertion macros for the three-tap feedback delay mixer
// used by the top level, no other dependencies
`ifndef MULTI_TAP_FEEDBACK_DELAY_MIXER_TOP_ASSERT_SVH
`define MULTI_TAP_FEEDBACK_DELAY_MIXER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MTFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mtfd assertion failed");

// next-cycle implication
`define MTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtfd assertion failed");

`else

`define MTFD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/mtfd_pkg.sv */
// shared constants and types of the three-tap feedback delay mixer
// no dependencies
`default_nettype none

package mtfd_pkg;

	localparam int DELAY_DEPTH_DEF = 65536;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int TAPS            = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// 0.0002 in Q0.32
	localparam int SMOOTH_COEF = 858993;

	// wet gain 0.3 and percent scale: out = (3*w*sum + 10*(100-w)*x) / 1000
	localparam int MIX_WET_MUL = 3;
	localparam int MIX_DRY_MUL = 10;
	localparam int MIX_DIVISOR = 1000;

	localparam logic [6:0]  WET_MAX    = 7'd100;
	localparam logic [6:0]  WET_RESET  = 7'd50;
	localparam logic [15:0] TGT_RESET  = 16'd24000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_A,
		REG_TARGET_B,
		REG_TARGET_C,
		REG_GAIN_A,
		REG_GAIN_B,
		REG_GAIN_C,
		REG_WET,
		REG_BYPASS
	} cfg_reg_t;

endpackage

`default_nettype wire

/* hdl/mtfd_if.sv */
// channel interfaces: sample input, mixed output and register writes
// depends on mtfd_pkg
`default_nettype none

interface mtfd_in_if #(
	parameter int SAMPLE_BITS = mtfd_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface mtfd_out_if #(
	parameter int SAMPLE_BITS = mtfd_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface mtfd_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [mtfd_pkg::CFG_IDX_W-1:0]       index;
	logic [mtfd_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/multi_tap_feedback_delay_mixer_top.sv */
// three-tap feedback delay mixer, top level
// channels: samples (sink) carries one signed sample per transaction,
// results (source) returns exactly one mixed sample per accepted sample,
// cfg (sink) writes one register per transaction, always ready
// register indexes: target delay a/b/c, feedback gain a/b/c, wet percent, bypass
// one sample is worked at a time, the next is taken after the result register
// has loaded; the divider skips its multiply when the mix saturates
// the sequence runs on the shared 33x21 multiplier (seven steps per tap,
// one read port per delay line), then three mix steps and the reciprocal
// divide by 1000
// the output register parts the two sides: a new sample is taken while the
// last result still waits; a stalled receiver holds the block in its final
// step until the result register is free
// reset clears control state, the smoothed delays and the write position;
// the delay lines need no clearing pass, a fill count makes entries not yet
// written read as zero, so samples are taken right after reset
// registers must be written only while no sample is in flight; the block itself does not enforce this
`default_nettype none

`include "multi_tap_feedback_delay_mixer_top_assert.svh"

module multi_tap_feedback_delay_mixer_top #(
	parameter int DELAY_DEPTH = mtfd_pkg::DELAY_DEPTH_DEF,
	parameter int SAMPLE_BITS = mtfd_pkg::SAMPLE_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mtfd_in_if.sink   samples,
	mtfd_out_if.source results,
	mtfd_cfg_if.sink  cfg
);
	import mtfd_pkg::*;

	localparam int AW     = $clog2(DELAY_DEPTH);
	localparam int SB     = SAMPLE_BITS;
	localparam int PA_W   = (SB + 2 > 33) ? SB + 2 : 33;
	localparam int PB_W   = 21;
	localparam int PR_W   = PA_W + PB_W;
	localparam int ACC_W  = SB + 11;
	localparam int FILL_W = AW + 1;

	localparam logic [FILL_W-1:0]     DEPTH_C = FILL_W'(DELAY_DEPTH);
	localparam logic [20:0]           LIM21   = 21'(DELAY_DEPTH - 1);
	localparam logic [AW-1:0]         WP_LAST = AW'(DELAY_DEPTH - 1);
	localparam logic [1:0]            TAP_LAST = 2'(TAPS - 1);
	localparam logic signed [PR_W-1:0] HALF32 = PR_W'(1) << 31;
	localparam logic signed [PR_W-1:0] HALF16 = PR_W'(1) << 15;
	localparam logic signed [SB+1:0]  V_MAX = {3'b000, {(SB-1){1'b1}}};
	localparam logic signed [SB+1:0]  V_MIN = {3'b111, {(SB-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE,
		S_SMOOTH,
		S_STEP,
		S_RDB,
		S_INTERP,
		S_READ,
		S_FBK,
		S_WRITE,
		S_MIXA,
		S_MIXB,
		S_MIXC,
		S_DIV
	} state_t;

	// configuration registers
	logic [15:0] tgt_q  [TAPS];
	logic [15:0] gain_q [TAPS];
	logic [6:0]  wet_q;
	logic        bypass_q;

	// sequencer and datapath state
	state_t                 state_q;
	logic [1:0]             tap_q;
	logic signed [SB-1:0]   x_q;
	logic signed [SB+1:0]   sum_q;
	logic [31:0]            sm_q [TAPS];
	logic signed [PR_W-1:0] prod_q;
	logic signed [SB-1:0]   a_q;
	logic                   va_q;
	logic                   vb_q;
	logic [AW-1:0]          addrb_q;
	logic [15:0]            frac_q;
	logic signed [SB-1:0]   rd_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [AW-1:0]          wp_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   outv_q;
	logic signed [SB-1:0]   outd_q;

	// combinational datapath
	logic signed [PA_W-1:0] mul_a;
	logic signed [PB_W-1:0] mul_b;
	logic [20:0]            tgt21_c;
	logic [15:0]            tgt_c;
	logic signed [32:0]     diff_c;
	logic signed [PR_W-1:0] step_c;
	logic [31:0]            sm_new_c;
	logic [20:0]            ip21_c;
	logic [AW-1:0]          ip_c;
	logic [AW:0]            suma_c;
	logic [AW-1:0]          addra_c;
	logic [AW:0]            kb1_c;
	logic [AW-1:0]          kb_c;
	logic [AW:0]            sumb_c;
	logic [AW-1:0]          addrb_c;
	logic                   va_c;
	logic                   vb_c;
	logic [AW-1:0]          raddr;
	logic [SB-1:0]          rdata [TAPS];
	logic signed [SB-1:0]   bdat_c;
	logic signed [PR_W-1:0] rd_full_c;
	logic signed [SB-1:0]   rd_c;
	logic signed [PR_W-1:0] fbk_full_c;
	logic signed [SB+1:0]   wr_sum_c;
	logic [SB-1:0]          wr_sat_c;
	logic [6:0]             wet_c;
	logic [8:0]             wet3_c;
	logic [9:0]             dry10_c;
	logic signed [ACC_W-1:0] mix_sum_c;
	logic                   div_start;
	logic                   div_busy;
	logic signed [SB-1:0]   div_quo;
	logic                   load_c;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TAPS; t++) begin
				tgt_q[t]  <= TGT_RESET;
				gain_q[t] <= '0;
			end
			wet_q    <= WET_RESET;
			bypass_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_TARGET_A: tgt_q[0]  <= cfg.data;
				REG_TARGET_B: tgt_q[1]  <= cfg.data;
				REG_TARGET_C: tgt_q[2]  <= cfg.data;
				REG_GAIN_A:   gain_q[0] <= cfg.data;
				REG_GAIN_B:   gain_q[1] <= cfg.data;
				REG_GAIN_C:   gain_q[2] <= cfg.data;
				REG_WET:      wet_q     <= cfg.data[6:0];
				REG_BYPASS:   bypass_q  <= cfg.data[0];
				default:      wet_q     <= wet_q;
			endcase
		end
	end

	// smoothing: step toward the clamped target
	assign tgt21_c = {5'b0, tgt_q[tap_q]};
	assign tgt_c   = (tgt21_c > LIM21) ? LIM21[15:0] : tgt_q[tap_q];
	assign diff_c  = $signed({1'b0, tgt_c, 16'b0}) - $signed({1'b0, sm_q[tap_q]});
	assign step_c  = (prod_q + HALF32) >>> 32;
	assign sm_new_c = sm_q[tap_q] + step_c[31:0];

	// read position: integer part clamped, both neighbors modulo depth
	assign ip21_c  = {5'b0, sm_new_c[31:16]};
	assign ip_c    = (ip21_c > LIM21) ? LIM21[AW-1:0] : ip21_c[AW-1:0];
	assign suma_c  = {1'b0, wp_q} + {1'b0, ip_c};
	assign addra_c = (suma_c >= DEPTH_C[AW:0]) ? AW'(suma_c - DEPTH_C[AW:0]) : suma_c[AW-1:0];
	assign kb1_c   = {1'b0, ip_c} + 1'b1;
	assign kb_c    = (kb1_c == DEPTH_C[AW:0]) ? '0 : kb1_c[AW-1:0];
	assign sumb_c  = {1'b0, wp_q} + {1'b0, kb_c};
	assign addrb_c = (sumb_c >= DEPTH_C[AW:0]) ? AW'(sumb_c - DEPTH_C[AW:0]) : sumb_c[AW-1:0];

	// an entry k samples behind the write position holds data once k items went by;
	// the write position itself only after a full wrap
	assign va_c = (ip_c != '0) ? ({1'b0, ip_c} <= fill_q) : (fill_q == DEPTH_C);
	assign vb_c = (kb_c != '0) ? ({1'b0, kb_c} <= fill_q) : (fill_q == DEPTH_C);

	assign raddr  = (state_q == S_STEP) ? addra_c : addrb_q;
	assign bdat_c = vb_q ? $signed(rdata[tap_q]) : '0;

	// interpolation: (a*65536 + (b-a)*f) / 65536, rounded
	assign rd_full_c = ((PR_W'(a_q) <<< 16) + prod_q + HALF16) >>> 16;
	assign rd_c      = rd_full_c[SB-1:0];

	// write back: input plus rounded feedback, saturated
	assign fbk_full_c = (prod_q + HALF16) >>> 16;
	assign wr_sum_c   = (SB+2)'(x_q) + $signed(fbk_full_c[SB+1:0]);
	always_comb begin
		if (wr_sum_c > V_MAX) begin
			wr_sat_c = V_MAX[SB-1:0];
		end else if (wr_sum_c < V_MIN) begin
			wr_sat_c = V_MIN[SB-1:0];
		end else begin
			wr_sat_c = wr_sum_c[SB-1:0];
		end
	end

	// mix weights; bypass leaves only the dry path
	assign wet_c   = bypass_q ? '0 : ((wet_q > WET_MAX) ? WET_MAX : wet_q);
	assign wet3_c  = 9'(wet_c) * 9'(MIX_WET_MUL);
	assign dry10_c = 10'(WET_MAX - wet_c) * 10'(MIX_DRY_MUL);
	assign mix_sum_c = acc_q + $signed(prod_q[ACC_W-1:0]);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_SMOOTH: begin
				mul_a = PA_W'(diff_c);
				mul_b = PB_W'(SMOOTH_COEF);
			end
			S_INTERP: begin
				mul_a = PA_W'(bdat_c) - PA_W'(a_q);
				mul_b = PB_W'($signed({1'b0, frac_q}));
			end
			S_FBK: begin
				mul_a = PA_W'(rd_q);
				mul_b = PB_W'($signed({1'b0, gain_q[tap_q]}));
			end
			S_MIXA: begin
				mul_a = PA_W'(sum_q);
				mul_b = PB_W'($signed({1'b0, wet3_c}));
			end
			S_MIXB: begin
				mul_a = PA_W'(x_q);
				mul_b = PB_W'($signed({1'b0, dry10_c}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// delay lines
	for (genvar t = 0; t < TAPS; t++) begin : g_line
		mtfd_tap_mem #(
			.DEPTH  (DELAY_DEPTH),
			.ADDR_W (AW),
			.DATA_W (SB)
		) u_mem (
			.clk   (clk),
			.we    ((state_q == S_WRITE) && (tap_q == 2'(t))),
			.waddr (wp_q),
			.wdata (wr_sat_c),
			.raddr (raddr),
			.rdata (rdata[t])
		);
	end

	assign div_start = (state_q == S_MIXC);

	mtfd_div1000 #(
		.SAMPLE_BITS (SB),
		.ACC_W       (ACC_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.value  (mix_sum_c),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// result register loads once the quotient is ready and the slot is free
	assign load_c = (state_q == S_DIV) && !div_busy && (!outv_q || results.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q   <= '0;
			wp_q    <= '0;
			fill_q  <= '0;
			outv_q  <= 1'b0;
			for (int t = 0; t < TAPS; t++) begin
				sm_q[t] <= '0;
			end
		end else begin
			prod_q <= mul_a * mul_b;
			if (load_c) begin
				outv_q <= 1'b1;
				outd_q <= div_quo;
			end else if (outv_q && results.ready) begin
				outv_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						x_q     <= samples.sample_in;
						sum_q   <= '0;
						tap_q   <= '0;
						state_q <= S_SMOOTH;
					end
				end
				S_SMOOTH: state_q <= S_STEP;
				S_STEP: begin
					sm_q[tap_q] <= sm_new_c;
					frac_q      <= sm_new_c[15:0];
					va_q        <= va_c;
					vb_q        <= vb_c;
					addrb_q     <= addrb_c;
					state_q     <= S_RDB;
				end
				S_RDB: begin
					a_q     <= va_q ? $signed(rdata[tap_q]) : '0;
					state_q <= S_INTERP;
				end
				S_INTERP: state_q <= S_READ;
				S_READ: begin
					rd_q    <= rd_c;
					sum_q   <= sum_q + (SB+2)'(rd_c);
					state_q <= S_FBK;
				end
				S_FBK: state_q <= S_WRITE;
				S_WRITE: begin
					if (tap_q == TAP_LAST) begin
						state_q <= S_MIXA;
					end else begin
						tap_q   <= tap_q + 1'b1;
						state_q <= S_SMOOTH;
					end
				end
				S_MIXA: state_q <= S_MIXB;
				S_MIXB: begin
					acc_q   <= $signed(prod_q[ACC_W-1:0]);
					state_q <= S_MIXC;
				end
				S_MIXC: begin
					wp_q    <= (wp_q == '0) ? WP_LAST : wp_q - 1'b1;
					fill_q  <= (fill_q == DEPTH_C) ? DEPTH_C : fill_q + 1'b1;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (load_c) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign samples.ready      = (state_q == S_IDLE);
	assign results.valid      = outv_q;
	assign results.sample_out = outd_q;

	`MTFD_ASSERT_NOW(a_div_start_idle, clk, arst_n, div_start, !div_busy)
	`MTFD_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= DEPTH_C)
	`MTFD_ASSERT_NOW(a_tap_range, clk, arst_n, state_q != S_IDLE, tap_q <= TAP_LAST)
	`MTFD_ASSERT_NEXT(a_wp_moves, clk, arst_n, state_q == S_MIXC, wp_q != $past(wp_q))

endmodule

`default_nettype wire

/* hdl/mtfd_tap_mem.sv */
// one delay line: simple dual-port memory, one write and one registered read
// no dependencies
`default_nettype none

module mtfd_tap_mem #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16,
	parameter int DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/mtfd_div1000.sv */
// rounding, saturating divide of the mix sum by 1000 through a reciprocal multiply
// depends on mtfd_pkg
`default_nettype none

module mtfd_div1000 #(
	parameter int SAMPLE_BITS = mtfd_pkg::SAMPLE_BITS_DEF,
	parameter int ACC_W       = mtfd_pkg::SAMPLE_BITS_DEF + 11
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [ACC_W-1:0]  value,
	output logic                          busy,
	output logic signed [SAMPLE_BITS-1:0] quo
);
	import mtfd_pkg::*;

	localparam int UW      = ACC_W + 1;
	localparam int DIV_ODD = MIX_DIVISOR / 8;
	localparam int NW      = SAMPLE_BITS + 7;
	localparam int KSH     = NW + 7;
	localparam int MW      = NW + 1;
	localparam int PW      = NW + MW;
	localparam logic [UW-1:0] OFFSET = UW'(MIX_DIVISOR) << (SAMPLE_BITS - 1);
	localparam logic [UW-1:0] HI_LIM = UW'(MIX_DIVISOR) << SAMPLE_BITS;
	// ceil(2^KSH / 125), exact floor quotient for every NW-bit dividend
	localparam logic [MW-1:0] RECIP =
		MW'(((longint'(1) << KSH) + longint'(DIV_ODD - 1)) / longint'(DIV_ODD));

	logic [UW-1:0]          u_c;
	logic [NW-1:0]          n_q;
	logic [PW-1:0]          prod_q;
	logic [SAMPLE_BITS-1:0] q_q;
	logic                   mul_q;

	// biased so the quotient is non-negative: floor((v+500)/1000) + 2^(n-1)
	assign u_c = UW'(value) + UW'(MIX_DIVISOR / 2) + OFFSET;

	// divide by 8 with a shift, then by 125 with the reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			mul_q <= 1'b0;
		end else if (start) begin
			if (u_c[UW-1]) begin
				q_q  <= '0;
				busy <= 1'b0;
			end else if (u_c >= HI_LIM) begin
				q_q  <= '1;
				busy <= 1'b0;
			end else begin
				n_q   <= u_c[SAMPLE_BITS+9:3];
				mul_q <= 1'b1;
				busy  <= 1'b1;
			end
		end else if (mul_q) begin
			prod_q <= n_q * RECIP;
			mul_q  <= 1'b0;
		end else if (busy) begin
			q_q  <= prod_q[KSH+SAMPLE_BITS-1:KSH];
			busy <= 1'b0;
		end
	end

	// remove the bias by flipping the sign bit
	assign quo = {~q_q[SAMPLE_BITS-1], q_q[SAMPLE_BITS-2:0]};

endmodule

`default_nettype wire
